@@ rtl/core/mtf_pkg.sv @@
package mtf_pkg;

   // width of every item and result field
   localparam int FIELD_W = 9;

   // default number of list cells
   localparam int MAX_ITEMS_DEF = 256;

   // list_size after reset
   localparam logic [FIELD_W-1:0] LIST_SIZE_RESET = 9'd256;

   // request kinds
   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

   // control flags that travel with a request down the cell chain
   typedef struct packed {
      logic valid;
      logic func;
      logic bad;
      logic found;
   } mtf_ctl_type;

endpackage

@@ rtl/core/mtf_cell.sv @@
module mtf_cell
   import mtf_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int INDEX     = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  mtf_ctl_type                      in_ctl,
   input  logic [$clog2(MAX_ITEMS)-1:0]     in_code,
   input  logic [$clog2(MAX_ITEMS)-1:0]     in_carry,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]   in_pos,
   output mtf_ctl_type                      out_ctl,
   output logic [$clog2(MAX_ITEMS)-1:0]     out_code,
   output logic [$clog2(MAX_ITEMS)-1:0]     out_carry,
   output logic [$clog2(MAX_ITEMS+1)-1:0]   out_pos
);

   localparam int CW = $clog2(MAX_ITEMS);
   localparam int PW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0] value_ff;
   logic [CW-1:0] value_in;
   mtf_ctl_type   ctl_ff;
   mtf_ctl_type   ctl_in;
   logic [CW-1:0] code_ff;
   logic [CW-1:0] carry_ff;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic          live;
   logic          hit;
   logic          take;

   // a request still searching looks at this cell
   assign live = in_ctl.valid && !in_ctl.bad && !in_ctl.found;
   assign hit  = live && (value_ff == in_code);
   assign take = live && (in_ctl.func == FUNC_ACCESS);

   // an access pushes the carried identifier in and the old one out
   always_comb begin
      value_in = take ? in_carry : value_ff;
      ctl_in = in_ctl;
      ctl_in.found = in_ctl.found | hit;
      pos_in = hit ? PW'(INDEX + 1) : in_pos;
   end

   // cell contents, reset to the identity order
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= CW'(INDEX);
      end else if (advance) begin
         value_ff <= value_in;
      end
   end

   // request stage to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         code_ff  <= in_code;
         carry_ff <= value_ff;
         pos_ff   <= pos_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_code  = code_ff;
   assign out_carry = carry_ff;
   assign out_pos   = pos_ff;

endmodule

@@ rtl/core/mtf_stats.sv @@
module mtf_stats
   import mtf_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  mtf_ctl_type                      in_ctl,
   input  logic [$clog2(MAX_ITEMS)-1:0]     in_code,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]   in_pos,
   output logic                             busy,
   output logic                             rsp_valid,
   output logic [FIELD_W-1:0]               rsp_position,
   output logic [FIELD_W-1:0]               rsp_least_pos,
   output logic [FIELD_W-1:0]               rsp_greatest_pos,
   output logic                             rsp_bad_item
);

   localparam int CW = $clog2(MAX_ITEMS);
   localparam int PW = $clog2(MAX_ITEMS + 1);

   // entry: seen flag over greatest position
   logic [PW:0]   stat_mem [MAX_ITEMS];

   logic          clr_active_ff;
   logic [CW-1:0] clr_cnt_ff;

   mtf_ctl_type   t2_ctl_ff;
   logic [CW-1:0] t2_code_ff;
   logic [PW-1:0] t2_pos_ff;
   logic [PW:0]   rdata_ff;

   logic          last_wr_valid_ff;
   logic [CW-1:0] last_wr_code_ff;
   logic [PW:0]   last_wr_data_ff;

   logic [PW:0]   entry;
   logic [PW-1:0] g_cur;
   logic [PW-1:0] g_new;
   logic [PW-1:0] least;
   logic          good;
   logic          wr_en;

   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  rsp_position_ff;
   logic [FIELD_W-1:0]  rsp_least_pos_ff;
   logic [FIELD_W-1:0]  rsp_greatest_pos_ff;
   logic                rsp_bad_item_ff;

   // clearing pass over the table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_cnt_ff == CW'(MAX_ITEMS - 1)) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + CW'(1);
         end
      end
   end

   assign busy = clr_active_ff;

   // second tail stage: request plus table read
   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ctl_ff <= '0;
      end else if (advance) begin
         t2_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t2_code_ff <= in_code;
         t2_pos_ff  <= in_pos;
         rdata_ff   <= stat_mem[in_code];
      end
   end

   // update of the entry, forwarding the write that the read missed
   always_comb begin
      if (last_wr_valid_ff && (last_wr_code_ff == t2_code_ff)) begin
         entry = last_wr_data_ff;
      end else begin
         entry = rdata_ff;
      end
      g_cur = entry[PW-1:0];
      g_new = (t2_pos_ff > g_cur) ? t2_pos_ff : g_cur;
      if (t2_ctl_ff.func == FUNC_ACCESS || entry[PW]) begin
         least = PW'(1);
      end else begin
         least = PW'(t2_code_ff) + PW'(1);
      end
      good  = t2_ctl_ff.valid && !t2_ctl_ff.bad;
      wr_en = advance && good && (t2_ctl_ff.func == FUNC_ACCESS);
   end

   // table writes: clearing pass or access update
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         stat_mem[clr_cnt_ff] <= {1'b0, PW'(clr_cnt_ff) + PW'(1)};
      end else if (wr_en) begin
         stat_mem[t2_code_ff] <= {1'b1, g_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else if (wr_en) begin
         last_wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_code_ff <= t2_code_ff;
         last_wr_data_ff <= {1'b1, g_new};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= t2_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && t2_ctl_ff.valid) begin
         if (t2_ctl_ff.bad) begin
            rsp_position_ff     <= '0;
            rsp_least_pos_ff    <= '0;
            rsp_greatest_pos_ff <= '0;
            rsp_bad_item_ff     <= 1'b1;
         end else begin
            rsp_position_ff     <= FIELD_W'(t2_pos_ff);
            rsp_least_pos_ff    <= FIELD_W'(least);
            rsp_greatest_pos_ff <= FIELD_W'(g_new);
            rsp_bad_item_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_least_pos    = rsp_least_pos_ff;
   assign rsp_greatest_pos = rsp_greatest_pos_ff;
   assign rsp_bad_item     = rsp_bad_item_ff;

`ifndef NO_ASSERTIONS
   // every good request has met its identifier by the end of the chain
   a_found_at_tail: assert property (@(posedge clock) disable iff (reset)
      good |-> t2_ctl_ff.found)
      else $error("request left the cell chain without a match");

   // table is never updated by a request while it is being cleared
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !wr_en)
      else $error("table write during clearing pass");

   // greatest position never below the position returned
   a_greatest_bound: assert property (@(posedge clock) disable iff (reset)
      good |-> (g_new >= t2_pos_ff) && (t2_pos_ff != '0))
      else $error("greatest position below current position");

   // a flagged result carries no positions
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_item_ff) |->
         (rsp_position_ff == '0) && (rsp_least_pos_ff == '0)
         && (rsp_greatest_pos_ff == '0))
      else $error("bad item result with nonzero fields");
`endif

endmodule

@@ rtl/core/move_to_front_position_tracker.sv @@
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_func, req_item
// rsp       out        rsp_valid / rsp_stall  rsp_position, rsp_least_pos,
//                                             rsp_greatest_pos, rsp_bad_item
// csr       in         csr_valid / csr_ready  csr_list_size
//
// one transfer per cycle sustained, and each request walks one cell per cycle,
// while no stall holds the chain; a result passes the cell registers, the second
// tail stage and the result register; the position table is swept after reset,
// with req_stall high during the sweep
// reset is synchronous; it restores the list order and list_size = 256
// rsp_stall, while a result is valid, freezes the whole chain and the tail, and raises req_stall
module move_to_front_position_tracker
   import mtf_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [FIELD_W-1:0]  req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [FIELD_W-1:0]  rsp_position,
   output logic [FIELD_W-1:0]  rsp_least_pos,
   output logic [FIELD_W-1:0]  rsp_greatest_pos,
   output logic                rsp_bad_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FIELD_W-1:0]  csr_list_size
);

   localparam int CW = $clog2(MAX_ITEMS);
   localparam int PW = $clog2(MAX_ITEMS + 1);

   logic [FIELD_W-1:0] list_size_ff;
   logic               advance;
   logic               busy;
   logic               item_bad;
   logic [FIELD_W-1:0] item_m1;

   mtf_ctl_type   chain_ctl   [MAX_ITEMS+1];
   logic [CW-1:0] chain_code  [MAX_ITEMS+1];
   logic [CW-1:0] chain_carry [MAX_ITEMS+1];
   logic [PW-1:0] chain_pos   [MAX_ITEMS+1];

   // list size register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_size_ff <= LIST_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         list_size_ff <= csr_list_size;
      end
   end

   // everything moves together unless a finished result is held
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || busy;

   // range check and entry into the first cell
   assign item_bad = (req_item == '0) || (req_item > list_size_ff)
                     || (32'(req_item) > MAX_ITEMS);
   assign item_m1  = req_item - FIELD_W'(1);

   always_comb begin
      chain_ctl[0].valid = req_valid && !req_stall;
      chain_ctl[0].func  = req_func;
      chain_ctl[0].bad   = item_bad;
      chain_ctl[0].found = 1'b0;
   end

   assign chain_code[0]  = CW'({{CW{1'b0}}, item_m1});
   assign chain_carry[0] = CW'({{CW{1'b0}}, item_m1});
   assign chain_pos[0]   = '0;

   // the list itself, one identifier per cell
   for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
      mtf_cell #(
         .MAX_ITEMS (MAX_ITEMS),
         .INDEX     (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_ctl    (chain_ctl[k]),
         .in_code   (chain_code[k]),
         .in_carry  (chain_carry[k]),
         .in_pos    (chain_pos[k]),
         .out_ctl   (chain_ctl[k+1]),
         .out_code  (chain_code[k+1]),
         .out_carry (chain_carry[k+1]),
         .out_pos   (chain_pos[k+1])
      );
   end

   // least and greatest positions per identifier
   mtf_stats #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_stats (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_ctl           (chain_ctl[MAX_ITEMS]),
      .in_code          (chain_code[MAX_ITEMS]),
      .in_pos           (chain_pos[MAX_ITEMS]),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_position     (rsp_position),
      .rsp_least_pos    (rsp_least_pos),
      .rsp_greatest_pos (rsp_greatest_pos),
      .rsp_bad_item     (rsp_bad_item)
   );

endmodule

@@ tb/mtf_checker.sv @@
module mtf_checker
   import mtf_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_func,
   input  logic [FIELD_W-1:0] req_item,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [FIELD_W-1:0] rsp_position,
   input  logic [FIELD_W-1:0] rsp_least_pos,
   input  logic [FIELD_W-1:0] rsp_greatest_pos,
   input  logic               rsp_bad_item,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [FIELD_W-1:0] csr_list_size,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] least;
      logic [FIELD_W-1:0] greatest;
      logic               bad;
   } pos_report_type;

   typedef struct packed {
      logic               func;
      logic [FIELD_W-1:0] item;
      pos_report_type     report;
   } queued_report_type;

   // tracked copy of the list order and per-item extremes
   logic [FIELD_W-1:0] order        [MAX_ITEMS];
   logic [FIELD_W-1:0] lowest_seen  [MAX_ITEMS];
   logic [FIELD_W-1:0] highest_seen [MAX_ITEMS];
   logic [FIELD_W-1:0] size_reg;

   queued_report_type queued_reports [$];

   // apply one request to the tracked list and return what the block must answer
   function automatic pos_report_type move_and_report(input logic func,
                                                      input logic [FIELD_W-1:0] id);
      pos_report_type     r;
      int                 lim;
      int                 slot;
      int                 k;
      logic [FIELD_W-1:0] code;
      r = '0;
      lim = (size_reg > MAX_ITEMS) ? MAX_ITEMS : int'(size_reg);
      if (id == 0 || id > lim) begin
         r.bad = 1'b1;
         return r;
      end
      code = id - 1'b1;
      slot = 0;
      for (k = 0; k < MAX_ITEMS; k++)
         if (order[k] == code) slot = k;
      r.position = FIELD_W'(slot + 1);
      if (func == FUNC_ACCESS) begin
         lowest_seen[code] = FIELD_W'(1);
         if (slot + 1 > highest_seen[code]) highest_seen[code] = FIELD_W'(slot + 1);
         for (k = slot; k > 0; k--) order[k] = order[k-1];
         order[0] = code;
         r.greatest = highest_seen[code];
      end else begin
         r.greatest = (slot + 1 > highest_seen[code]) ? FIELD_W'(slot + 1)
                                                      : highest_seen[code];
      end
      r.least = lowest_seen[code];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      pos_report_type    got;
      queued_report_type want;
      int                k;
      if (reset) begin
         // list and extremes back to identity order
         for (k = 0; k < MAX_ITEMS; k++) begin
            order[k]        = FIELD_W'(k);
            lowest_seen[k]  = FIELD_W'(k + 1);
            highest_seen[k] = FIELD_W'(k + 1);
         end
         size_reg = LIST_SIZE_RESET;
         errors   = 0;
         queued_reports.delete();
      end else begin
         // register write transfer
         if (csr_valid && csr_ready) size_reg = csr_list_size;

         // result transfer, checked against the oldest queued report
         if (rsp_valid && !rsp_stall) begin
            got.position = rsp_position;
            got.least    = rsp_least_pos;
            got.greatest = rsp_greatest_pos;
            got.bad      = rsp_bad_item;
            if (queued_reports.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: pos %0d least %0d greatest %0d bad %0b",
                           got.position, got.least, got.greatest, got.bad);
               errors++;
            end else begin
               want = queued_reports.pop_front();
               if (got.position !== want.report.position ||
                   got.least    !== want.report.least    ||
                   got.greatest !== want.report.greatest ||
                   got.bad      !== want.report.bad) begin
                  if (errors < 10)
                     $display({"mismatch func %0b item %0d: expected pos %0d least %0d ",
                               "greatest %0d bad %0b, got pos %0d least %0d greatest %0d ",
                               "bad %0b"},
                              want.func, want.item, want.report.position,
                              want.report.least, want.report.greatest, want.report.bad,
                              got.position, got.least, got.greatest, got.bad);
                  errors++;
               end
            end
         end

         // request transfer
         if (req_valid && !req_stall) begin
            want.func   = req_func;
            want.item   = req_item;
            want.report = move_and_report(req_func, req_item);
            queued_reports = {queued_reports, want};
         end
      end
      pending = queued_reports.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   import mtf_pkg::*;

   localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
   localparam int HOLD_CYCLES = 400;
   localparam int RUN_LIMIT   = 400000;
   localparam int NUM_PHASES  = 9;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_func      = FUNC_ACCESS;
   logic [FIELD_W-1:0] req_item      = '0;
   logic               rsp_stall     = 1'b0;
   logic               csr_valid     = 1'b0;
   logic [FIELD_W-1:0] csr_list_size = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [FIELD_W-1:0] rsp_position;
   logic [FIELD_W-1:0] rsp_least_pos;
   logic [FIELD_W-1:0] rsp_greatest_pos;
   logic               rsp_bad_item;
   logic               csr_ready;

   int errors;
   int pending;

   // no random idling on either side while set
   bit calm         = 1'b0;
   // asks the receiver for one long hold-off
   bit hold_pending = 1'b0;
   // receiver side: the hold-off has been served
   bit hold_taken   = 1'b0;

   // list sizes per phase, extremes included, and items sent in each
   int phase_size  [NUM_PHASES] = '{511, 0, 1, 2, 37, 256, 300, 160, 9};
   int phase_count [NUM_PHASES] = '{150, 20, 30, 40, 120, 150, 300, 120, 100};

   always #5 clock = ~clock;

   move_to_front_position_tracker #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_least_pos    (rsp_least_pos),
      .rsp_greatest_pos (rsp_greatest_pos),
      .rsp_bad_item     (rsp_bad_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_list_size    (csr_list_size)
   );

   mtf_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_least_pos    (rsp_least_pos),
      .rsp_greatest_pos (rsp_greatest_pos),
      .rsp_bad_item     (rsp_bad_item),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_list_size    (csr_list_size),
      .errors           (errors),
      .pending          (pending)
   );

   // offer one request, with random gaps, and wait for its transfer
   task automatic offer_request(input logic f, input logic [FIELD_W-1:0] id);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_item  <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // wait until every queued result is back, then write list_size
   task automatic write_list_size(input int value);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_list_size <= FIELD_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly valid identifiers, a share near the front, some noise over the whole field
   function automatic logic [FIELD_W-1:0] pick_item(input int eff);
      int roll;
      roll = $urandom_range(99);
      if (eff == 0 || roll < 10) return FIELD_W'($urandom_range((1 << FIELD_W) - 1));
      if (roll < 35) return FIELD_W'($urandom_range(eff < 8 ? eff : 8, 1));
      return FIELD_W'($urandom_range(eff, 1));
   endfunction

   // receiver: random stall, one long hold-off on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_pending && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 10);
      end
   end

   initial begin : stimulus
      int p;
      int n;
      int eff;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: back and front of the full list, reports, bad identifiers
      offer_request(FUNC_ACCESS, 9'd256);
      offer_request(FUNC_REPORT, 9'd256);
      offer_request(FUNC_REPORT, 9'd255);
      offer_request(FUNC_ACCESS, 9'd255);
      offer_request(FUNC_ACCESS, 9'd256);
      offer_request(FUNC_REPORT, 9'd1);
      offer_request(FUNC_ACCESS, 9'd1);
      offer_request(FUNC_REPORT, 9'd1);
      offer_request(FUNC_ACCESS, 9'd1);
      offer_request(FUNC_ACCESS, 9'd0);
      offer_request(FUNC_REPORT, 9'd0);
      offer_request(FUNC_ACCESS, 9'd511);
      offer_request(FUNC_REPORT, 9'd511);
      offer_request(FUNC_ACCESS, 9'd257);
      offer_request(FUNC_ACCESS, 9'd128);
      offer_request(FUNC_REPORT, 9'd128);
      offer_request(FUNC_REPORT, 9'd170);
      offer_request(FUNC_ACCESS, 9'd170);
      offer_request(FUNC_REPORT, 9'd256);
      offer_request(FUNC_ACCESS, 9'd2);

      // random phases over several list sizes
      for (p = 0; p < NUM_PHASES; p++) begin
         write_list_size(phase_size[p]);
         eff  = (phase_size[p] > MAX_ITEMS) ? MAX_ITEMS : phase_size[p];
         calm = (p == 5);
         if (p == 6) hold_pending = 1'b1;
         for (n = 0; n < phase_count[p]; n++)
            offer_request(($urandom_range(99) < 60) ? FUNC_ACCESS : FUNC_REPORT,
                          pick_item(eff));
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain, then let the chain settle
      do @(negedge clock); while (pending != 0);
      repeat (MAX_ITEMS + 8) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT * 10);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/mtf_stats.sv
rtl/core/move_to_front_position_tracker.sv
tb/mtf_checker.sv
tb/testbench.sv
